@@ src/vc3_pkg.sv @@
// ----------------------------------------------------------------------------
// vc3_pkg: shared types and constants for vector_cosine_3d
// Beat payloads for both channels and the fixed field widths.
// ----------------------------------------------------------------------------
package vc3_pkg;

	localparam int COORD_BITS    = 32;   // coordinate width, two's complement
	localparam int COS_BITS      = 16;   // cosine field width
	localparam int COS_FRAC_BITS = 14;   // cosine fraction bits, Q1.14
	localparam int DIGIT_BITS    = 8;    // multiplier digit per cell

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_x;
		logic signed [COORD_BITS-1:0] a_y;
		logic signed [COORD_BITS-1:0] a_z;
		logic signed [COORD_BITS-1:0] b_x;
		logic signed [COORD_BITS-1:0] b_y;
		logic signed [COORD_BITS-1:0] b_z;
	} vec_t;

	typedef struct packed {
		logic signed [COS_BITS-1:0] cosine;
		logic                       degenerate;
	} cos_t;

	// side info that rides along the late pipeline
	typedef struct packed {
		logic dot_neg;
		logic degenerate;
	} side_t;

endpackage

@@ src/vc3_mul.sv @@
// ----------------------------------------------------------------------------
// vc3_mul: shift-add multiplier chain
// Unsigned products of LANES operand pairs, one digit of b per cell, each
// cell registered. A valid bit and a tag travel with the operands.
// ----------------------------------------------------------------------------
module vc3_mul #(
	parameter int AW    = 32,
	parameter int BW    = 32,
	parameter int LANES = 1,
	parameter int TAG_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [TAG_W-1:0]              in_tag,
	input  logic [LANES-1:0][AW-1:0]      a,
	input  logic [LANES-1:0][BW-1:0]      b,
	output logic                          out_vld,
	output logic [TAG_W-1:0]              out_tag,
	output logic [LANES-1:0][AW+BW-1:0]   p
);

	localparam int DW  = vc3_pkg::DIGIT_BITS;
	localparam int NC  = (BW + DW - 1) / DW;
	localparam int BPW = NC * DW;
	localparam int PW  = AW + BW;

	logic                        vld_q [NC];
	logic [TAG_W-1:0]            tag_q [NC];
	logic [LANES-1:0][AW-1:0]    a_q   [NC];
	logic [LANES-1:0][BPW-1:0]   b_q   [NC];
	logic [LANES-1:0][PW-1:0]    acc_q [NC];

	for (genvar k = 0; k < NC; k++) begin : g_cell
		logic                        vi;
		logic [TAG_W-1:0]            ti;
		logic [LANES-1:0][AW-1:0]    ai;
		logic [LANES-1:0][BPW-1:0]   bi;
		logic [LANES-1:0][PW-1:0]    ci;
		logic [LANES-1:0][PW-1:0]    cn;

		if (k == 0) begin : g_first
			always_comb begin
				vi = in_vld;
				ti = in_tag;
				ai = a;
				for (int l = 0; l < LANES; l++) begin
					bi[l] = BPW'(b[l]);
					ci[l] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				vi = vld_q[k-1];
				ti = tag_q[k-1];
				ai = a_q[k-1];
				bi = b_q[k-1];
				ci = acc_q[k-1];
			end
		end

		// partial product of this digit, aligned to its weight
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				cn[l] = ci[l] + (PW'(ai[l] * bi[l][k*DW +: DW]) << (k * DW));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_q[k] <= ti;
				a_q[k]   <= ai;
				b_q[k]   <= bi;
				acc_q[k] <= cn;
			end
		end
	end

	assign out_vld = vld_q[NC-1];
	assign out_tag = tag_q[NC-1];
	assign p       = acc_q[NC-1];

endmodule

@@ src/vc3_root_cell.sv @@
// ----------------------------------------------------------------------------
// vc3_root_cell: one bit of the cosine magnitude
// Tries to set bit BIT of c and keeps the residue r = D - k^2 P and
// q = k P (k = 2c - 1) up to date with shifts and adds only.
// ----------------------------------------------------------------------------
module vc3_root_cell #(
	parameter int TW      = 162,
	parameter int PW      = 128,
	parameter int CW      = 15,
	parameter int BIT     = 0,
	parameter int TOP_BIT = 14,
	parameter int TAG_W   = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [TAG_W-1:0]     in_tag,
	input  logic signed [TW-1:0] in_r,
	input  logic signed [TW-1:0] in_q,
	input  logic [PW-1:0]        in_p,
	input  logic [CW-1:0]        in_c,
	output logic                 out_vld,
	output logic [TAG_W-1:0]     out_tag,
	output logic signed [TW-1:0] out_r,
	output logic signed [TW-1:0] out_q,
	output logic [PW-1:0]        out_p,
	output logic [CW-1:0]        out_c
);

	localparam bit IS_TOP = (BIT == TOP_BIT);

	logic signed [TW-1:0] p_ext;
	logic signed [TW-1:0] t;
	logic                 skip;
	logic                 take;

	assign p_ext = signed'(TW'(in_p));
	// once c reached 1.0 no lower bit may be added
	assign skip  = !IS_TOP && in_c[TOP_BIT];
	assign t     = in_r - (in_q <<< (BIT + 2)) - (p_ext <<< (2 * BIT + 2));
	assign take  = !skip && !t[TW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_tag <= in_tag;
			out_p   <= in_p;
			out_r   <= take ? t : in_r;
			out_q   <= take ? (in_q + (p_ext <<< (BIT + 1))) : in_q;
			out_c   <= in_c | (CW'(take) << BIT);
		end
	end

endmodule

@@ src/vector_cosine_3d.sv @@
// ----------------------------------------------------------------------------
// vector_cosine_3d: cosine of the angle between two 3D vectors
// Exact dot product and lengths, bitwise root-free quotient, clamped Q1.14.
// ----------------------------------------------------------------------------
// Takes one vector pair per beat and returns one cosine beat per pair, in
// order, with a sustained rate of one beat per cycle while the skid register
// is empty. The pipeline runs through the magnitude stage, the coordinate
// multiplier chain (C = 4 8-bit digit cells for a 32-bit multiplier), the sums,
// the dot/length stage, the 64-bit multiplier chain (8 cells) for |a|^2|b|^2
// and dot^2, the residue setup, one cell per cosine bit, and the output register.
// The result is exact: the magnitude is rounded to nearest, ties away from
// zero, and never exceeds 1.0. A zero-length vector gives -1.0 with the
// degenerate flag set. A one-beat skid register behind the output lets the
// pipeline keep advancing after the output stalls, until a beat has to be
// parked in it.
// ----------------------------------------------------------------------------
module vector_cosine_3d (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vec_valid,
	output logic          vec_stall,
	input  vc3_pkg::vec_t vec,
	output logic          cos_valid,
	input  logic          cos_stall,
	output vc3_pkg::cos_t cos
);

	localparam int CB  = vc3_pkg::COORD_BITS;
	localparam int SW  = 2 * CB;                  // squares and sums
	localparam int PW  = 4 * CB;                  // |a|^2|b|^2 and dot^2
	localparam int F   = vc3_pkg::COS_FRAC_BITS;
	localparam int CW  = F + 1;                   // cosine magnitude
	localparam int TW  = 4 * CB + 2 * F + 6;      // signed residue
	localparam int STW = $bits(vc3_pkg::side_t);

	// global advance: pipeline moves while the skid register is empty
	logic en;
	logic skid_v_q;
	assign en        = !skid_v_q;
	assign vec_stall = skid_v_q;

	// ---- stage 1: magnitudes and sign of each product ----------------------
	logic                vld_s1;
	logic [5:0][CB-1:0]  mag_s1;
	logic [2:0]          xneg_s1;
	logic [5:0][CB-1:0]  raw;

	assign raw = {vec.b_z, vec.b_y, vec.b_x, vec.a_z, vec.a_y, vec.a_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				// most negative value keeps its full magnitude
				mag_s1[i] <= raw[i][CB-1] ? (~raw[i] + CB'(1)) : raw[i];
			end
			for (int i = 0; i < 3; i++) begin
				xneg_s1[i] <= raw[i][CB-1] ^ raw[i+3][CB-1];
			end
		end
	end

	// ---- coordinate products: a.b terms, |a|^2 and |b|^2 terms -------------
	logic [8:0][CB-1:0] m1_a;
	logic [8:0][CB-1:0] m1_b;
	logic [8:0][SW-1:0] m1_p;
	logic               m1_vld;
	logic [2:0]         m1_xneg;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m1_a[i]   = mag_s1[i];
			m1_b[i]   = mag_s1[i+3];
			m1_a[i+3] = mag_s1[i];
			m1_b[i+3] = mag_s1[i];
			m1_a[i+6] = mag_s1[i+3];
			m1_b[i+6] = mag_s1[i+3];
		end
	end

	vc3_mul #(
		.AW(CB), .BW(CB), .LANES(9), .TAG_W(3)
	) u_mul_coord (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s1),
		.in_tag  (xneg_s1),
		.a       (m1_a),
		.b       (m1_b),
		.out_vld (m1_vld),
		.out_tag (m1_xneg),
		.p       (m1_p)
	);

	// ---- stage 2: split dot product by sign, sum the squares ---------------
	logic          vld_s2;
	logic [SW-1:0] pos_s2, neg_s2, na_s2, nb_s2;
	logic [SW-1:0] pos_c, neg_c;

	always_comb begin
		pos_c = '0;
		neg_c = '0;
		for (int i = 0; i < 3; i++) begin
			if (m1_xneg[i]) begin
				neg_c = neg_c + m1_p[i];
			end else begin
				pos_c = pos_c + m1_p[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= m1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s2 <= pos_c;
			neg_s2 <= neg_c;
			na_s2  <= m1_p[3] + m1_p[4] + m1_p[5];
			nb_s2  <= m1_p[6] + m1_p[7] + m1_p[8];
		end
	end

	// ---- stage 3: |dot|, its sign, zero-length check -----------------------
	logic            vld_s3;
	logic [SW-1:0]   dot_s3, na_s3, nb_s3;
	vc3_pkg::side_t  side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3             <= (pos_s2 >= neg_s2) ? (pos_s2 - neg_s2) : (neg_s2 - pos_s2);
			side_s3.dot_neg    <= pos_s2 < neg_s2;
			side_s3.degenerate <= (na_s2 == '0) || (nb_s2 == '0);
			na_s3              <= na_s2;
			nb_s3              <= nb_s2;
		end
	end

	// ---- wide products: P = |a|^2|b|^2 and dot^2 ---------------------------
	logic [1:0][SW-1:0] m2_a;
	logic [1:0][SW-1:0] m2_b;
	logic [1:0][PW-1:0] m2_p;
	logic               m2_vld;
	logic [STW-1:0]     m2_side;

	assign m2_a = {dot_s3, na_s3};
	assign m2_b = {dot_s3, nb_s3};

	vc3_mul #(
		.AW(SW), .BW(SW), .LANES(2), .TAG_W(STW)
	) u_mul_wide (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.in_tag  (side_s3),
		.a       (m2_a),
		.b       (m2_b),
		.out_vld (m2_vld),
		.out_tag (m2_side),
		.p       (m2_p)
	);

	// ---- stage 4: residue setup, k = -1 so r = D - P and q = -P ------------
	logic                 vld_s4;
	logic [STW-1:0]       side_s4;
	logic signed [TW-1:0] r_s4, q_s4;
	logic [PW-1:0]        p_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= m2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= m2_side;
			p_s4    <= m2_p[0];
			r_s4    <= signed'(TW'(m2_p[1]) << (2 * F + 2)) - signed'(TW'(m2_p[0]));
			q_s4    <= -signed'(TW'(m2_p[0]));
		end
	end

	// ---- cosine bits, most significant first, one cell each ----------------
	logic                 c_vld  [F+2];
	logic [STW-1:0]       c_side [F+2];
	logic signed [TW-1:0] c_r    [F+2];
	logic signed [TW-1:0] c_q    [F+2];
	logic [PW-1:0]        c_p    [F+2];
	logic [CW-1:0]        c_c    [F+2];

	assign c_vld[0]  = vld_s4;
	assign c_side[0] = side_s4;
	assign c_r[0]    = r_s4;
	assign c_q[0]    = q_s4;
	assign c_p[0]    = p_s4;
	assign c_c[0]    = '0;

	for (genvar j = 0; j <= F; j++) begin : g_bit
		vc3_root_cell #(
			.TW(TW), .PW(PW), .CW(CW), .BIT(F - j), .TOP_BIT(F), .TAG_W(STW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (c_vld[j]),
			.in_tag  (c_side[j]),
			.in_r    (c_r[j]),
			.in_q    (c_q[j]),
			.in_p    (c_p[j]),
			.in_c    (c_c[j]),
			.out_vld (c_vld[j+1]),
			.out_tag (c_side[j+1]),
			.out_r   (c_r[j+1]),
			.out_q   (c_q[j+1]),
			.out_p   (c_p[j+1]),
			.out_c   (c_c[j+1])
		);
	end

	// ---- result formatting: sign, degenerate case --------------------------
	vc3_pkg::side_t side_f;
	vc3_pkg::cos_t  pipe_d;
	logic [31:0]    c_ext, one_ext, cos_w;
	logic           pipe_v;

	assign side_f  = c_side[F+1];
	assign pipe_v  = c_vld[F+1];
	assign c_ext   = 32'(c_c[F+1]);
	assign one_ext = 32'(1) << F;
	assign cos_w   = side_f.degenerate ? (32'(0) - one_ext) :
	                 side_f.dot_neg    ? (32'(0) - c_ext)   : c_ext;

	assign pipe_d.cosine     = signed'(cos_w[vc3_pkg::COS_BITS-1:0]);
	assign pipe_d.degenerate = side_f.degenerate;

	// ---- output register with one skid entry -------------------------------
	logic          out_v_q;
	vc3_pkg::cos_t out_q, skid_q;
	logic          take_out;

	assign take_out  = out_v_q && !cos_stall;
	assign cos_valid = out_v_q;
	assign cos       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en && pipe_v) begin
			if (!out_v_q || take_out) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take_out) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && pipe_v) begin
			if (!out_v_q || take_out) begin
				out_q <= pipe_d;
			end else begin
				skid_q <= pipe_d;
			end
		end else if (take_out && skid_v_q) begin
			out_q <= skid_q;
		end
	end

endmodule

@@ tb/vc3_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vc3_checker: cosine predictor and in-order result checker
// Watches both channels, computes the exact clamped cosine of each accepted
// pair and compares every accepted cosine beat against the oldest one.
// ----------------------------------------------------------------------------
module vc3_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vec_valid,
	input  logic          vec_stall,
	input  vc3_pkg::vec_t vec,
	input  logic          cos_valid,
	input  logic          cos_stall,
	input  vc3_pkg::cos_t cos,
	output int            errors,
	output int            pending,
	output int            checked
);

	localparam int FRAC = vc3_pkg::COS_FRAC_BITS;
	localparam logic [199:0] ONE = 200'd1 << FRAC;

	vc3_pkg::cos_t cos_q[$];

	// exact cosine: largest c <= 1.0 with (2c-1)^2 * |a|^2|b|^2 <= 4 dot^2 2^2F
	function automatic vc3_pkg::cos_t cosine_of(vc3_pkg::vec_t v);
		logic signed [67:0] dot, na, nb;
		logic [199:0] mag, prod, dsq, cand, acc, c;
		vc3_pkg::cos_t r;
		dot = 68'(v.a_x) * 68'(v.b_x) + 68'(v.a_y) * 68'(v.b_y) + 68'(v.a_z) * 68'(v.b_z);
		na = 68'(v.a_x) * 68'(v.a_x) + 68'(v.a_y) * 68'(v.a_y) + 68'(v.a_z) * 68'(v.a_z);
		nb = 68'(v.b_x) * 68'(v.b_x) + 68'(v.b_y) * 68'(v.b_y) + 68'(v.b_z) * 68'(v.b_z);
		if (na == 0 || nb == 0) begin
			r.cosine = -16'(ONE);
			r.degenerate = 1'b1;
			return r;
		end
		mag = (dot < 0) ? 200'(-dot) : 200'(dot);
		prod = 200'(na) * 200'(nb);
		dsq = (mag * mag) << (2 * FRAC + 2);
		c = '0;
		for (int b = FRAC; b >= 0; b--) begin
			cand = c | (200'd1 << b);
			if (cand <= ONE) begin
				acc = 2 * cand - 1;
				acc = acc * acc * prod;
				if (acc <= dsq)
					c = cand;
			end
		end
		r.cosine = (dot < 0) ? -16'(c) : 16'(c);
		r.degenerate = 1'b0;
		return r;
	endfunction

	task automatic report(string what, vc3_pkg::cos_t got, vc3_pkg::cos_t want);
		$display("MISMATCH %s: got cosine %0d degenerate %0b, want cosine %0d degenerate %0b",
			what, got.cosine, got.degenerate, want.cosine, want.degenerate);
		errors++;
	endtask

	always @(posedge clk) begin
		vc3_pkg::cos_t want;
		if (arst_n) begin
			if (vec_valid && !vec_stall)
				cos_q.push_back(cosine_of(vec));
			if (cos_valid && !cos_stall) begin
				if (cos_q.size() == 0) begin
					$display("MISMATCH unexpected beat: cosine %0d", cos.cosine);
					errors++;
				end else begin
					want = cos_q.pop_front();
					if (cos.cosine !== want.cosine)
						report("cosine", cos, want);
					else if (cos.degenerate !== want.degenerate)
						report("degenerate", cos, want);
					checked++;
				end
			end
			pending = cos_q.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top of the vector_cosine_3d testbench
// Drives directed and random vector pairs under three idle mixes plus a long
// output hold-off and a drain after each mix; the checker does all comparing.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG = 5000;  // cycles with no beat on either side
	localparam int HOLD_CYC = 300;   // long output hold-off, fills the pipe
	localparam int TAIL     = 100;   // idle wait before the final report

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           vec_valid = 1'b0;
	logic           vec_stall;
	vc3_pkg::vec_t  vec = '0;
	logic           cos_valid;
	logic           cos_stall = 1'b0;
	vc3_pkg::cos_t  cos;

	int errors, pending, checked;
	int send_idle = 13;   // percent of cycles the sender skips
	int recv_idle = 59;   // percent of cycles the receiver stalls
	bit hold_req = 0;
	bit hold_done = 0;
	int quiet = 0;
	int sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	vector_cosine_3d u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.vec_valid(vec_valid),
		.vec_stall(vec_stall),
		.vec      (vec),
		.cos_valid(cos_valid),
		.cos_stall(cos_stall),
		.cos      (cos)
	);

	vc3_checker u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.vec_valid(vec_valid),
		.vec_stall(vec_stall),
		.vec      (vec),
		.cos_valid(cos_valid),
		.cos_stall(cos_stall),
		.cos      (cos),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	// receiver: random stalls, or a long counted hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				for (int i = 0; i < HOLD_CYC; i++) begin
					cos_stall <= 1'b1;
					@(posedge clk);
				end
				hold_done = 1;
			end
			cos_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// watchdog: any accepted beat resets the count
	always @(posedge clk) begin
		if ((vec_valid && !vec_stall) || (cos_valid && !cos_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("watchdog expired, %0d beats outstanding", pending);
			$display("tb NOT OK");
			$finish;
		end
	end

	// one beat: random idle gap first, then hold until accepted
	task automatic send(vc3_pkg::vec_t v);
		while ($urandom_range(99) < send_idle) begin
			vec_valid <= 1'b0;
			@(posedge clk);
		end
		vec <= v;
		vec_valid <= 1'b1;
		@(posedge clk);
		while (vec_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		vec_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] small_coord();
		return 32'($signed($urandom_range(0, 511)) - 256);
	endfunction

	function automatic vc3_pkg::vec_t mk(logic [31:0] ax, ay, az, bx, by, bz);
		vc3_pkg::vec_t v;
		v.a_x = ax; v.a_y = ay; v.a_z = az;
		v.b_x = bx; v.b_y = by; v.b_z = bz;
		return v;
	endfunction

	// random pair; shapes lean toward the clamp, zero dot and zero length
	function automatic vc3_pkg::vec_t rand_pair();
		vc3_pkg::vec_t v;
		int k;
		int shape;
		shape = $urandom_range(9);
		case (shape)
			0, 1, 2: begin
				v = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
			3, 4: begin
				v = mk(small_coord(), small_coord(), small_coord(),
					small_coord(), small_coord(), small_coord());
			end
			5: begin
				// b = k * a: cosine at +/-1.0
				k = $signed($urandom_range(0, 14)) - 7;
				if (k == 0) k = 1;
				v = mk(small_coord(), small_coord(), small_coord(), 0, 0, 0);
				v.b_x = v.a_x * k; v.b_y = v.a_y * k; v.b_z = v.a_z * k;
			end
			6: begin
				// orthogonal pair: dot product exactly zero
				v = mk($urandom >> 2, $urandom >> 2, 0, 0, 0, $urandom);
				v.b_x = -v.a_y; v.b_y = v.a_x;
			end
			7: begin
				// one vector zero
				v = mk($urandom, $urandom, $urandom, 0, 0, 0);
				if ($urandom_range(1)) v = mk(0, 0, 0, v.a_x, v.a_y, v.a_z);
			end
			8: begin
				// nearly parallel: large base with small perturbation
				v = mk($urandom, $urandom, $urandom, 0, 0, 0);
				v.b_x = v.a_x + small_coord(); v.b_y = v.a_y + small_coord();
				v.b_z = v.a_z + small_coord();
			end
			default: begin
				// extreme coordinates mixed with random
				v = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				if ($urandom_range(1)) v.a_x = 32'h8000_0000;
				if ($urandom_range(1)) v.b_y = 32'h7fff_ffff;
				if ($urandom_range(1)) v.b_z = 32'h8000_0000;
			end
		endcase
		return v;
	endfunction

	initial begin
		vc3_pkg::vec_t dir[$];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero lengths, clamp, zero dot, extremes, unit axes
		dir.push_back(mk(0, 0, 0, 0, 0, 0));
		dir.push_back(mk(0, 0, 0, 32'h0001_0000, 0, 0));
		dir.push_back(mk(0, 32'h0001_0000, 0, 0, 0, 0));
		dir.push_back(mk(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0));
		dir.push_back(mk(32'h0001_0000, 0, 0, 32'hffff_0000, 0, 0));
		dir.push_back(mk(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0));
		dir.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		dir.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		dir.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		dir.push_back(mk(32'h8000_0000, 0, 0, 0, 0, 32'h7fff_ffff));
		dir.push_back(mk(1, 0, 0, 1, 1, 0));
		dir.push_back(mk(1, 0, 0, 32'hffff_ffff, 1, 1));
		dir.push_back(mk(1, 1, 1, 1, 1, 0));
		dir.push_back(mk(32'hffff_ffff, 0, 0, 0, 0, 0));
		dir.push_back(mk(3, 4, 0, 4, 3, 0));
		dir.push_back(mk(32'h7fff_ffff, 1, 0, 1, 32'h8000_0000, 0));
		dir.push_back(mk(0, 0, 1, 0, 0, 32'h8000_0000));
		foreach (dir[i])
			send(dir[i]);

		// three idle mixes, one full hold-off, a drain after each mix
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle = 13; recv_idle = 59; end
				1: begin send_idle = 59; recv_idle = 13; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			for (int n = 0; n < 500; n++) begin
				if (ph == 0 && n == 100)
					hold_req = 1;
				send(rand_pair());
			end
			drain();
		end

		repeat (TAIL) @(posedge clk);
		$display("%0d pairs sent, %0d cosines checked, across directed extremes and",
			sent, checked);
		$display("random shapes under three idle mixes, a long hold-off and drains");
		if (errors == 0 && pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
src/vc3_pkg.sv
src/vc3_mul.sv
src/vc3_root_cell.sv
src/vector_cosine_3d.sv
tb/vc3_checker.sv
tb/tb.sv
